FILE: rtl/core/mlp_pkg.sv
// Shared types, constants and the sigmoid table of the two-layer perceptron.
`default_nettype none
package mlp_pkg;

  localparam int MAX_INPUTS      = 32;
  localparam int MAX_HIDDEN      = 32;
  localparam int MAX_OUTPUTS     = 16;
  localparam int WEIGHT_DEPTH    = 2048;
  localparam int SIGMOID_ENTRIES = 1024;

  // Fixed field widths.
  localparam int WIDX_W    = 11;
  localparam int DATA_W    = 16;
  localparam int OIDX_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 6;
  localparam int ICNT_REG_W = 6;
  localparam int HCNT_REG_W = 6;
  localparam int OCNT_REG_W = 5;

  // Derived widths.
  localparam int WADDR_W   = $clog2(WEIGHT_DEPTH);
  localparam int FEAT_AW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HID_AW    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int NI_W      = $clog2(MAX_INPUTS + 1);
  localparam int NH_W      = $clog2(MAX_HIDDEN + 1);
  localparam int NO_W      = $clog2(MAX_OUTPUTS + 1);
  localparam int MAX_SLOTS = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int SLOT_W    = $clog2(MAX_SLOTS + 1);
  localparam int MAX_UNITS = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int UNIT_W    = $clog2(MAX_UNITS + 1);
  localparam int MAX_SPAN  = (MAX_INPUTS + 1) * MAX_HIDDEN + (MAX_HIDDEN + 1) * MAX_OUTPUTS;
  localparam int SPAN_W    = $clog2(MAX_SPAN + 1);
  localparam int SEQ_AW    = (SPAN_W > WADDR_W) ? SPAN_W : WADDR_W;
  localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_HALF  = SIGMOID_ENTRIES / 2;

  // Square root chain: one cell per result bit.
  localparam int SQRT_STEPS = 16;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int REM_W      = SQRT_STEPS + 3;

  // MAC datapath widths.
  localparam int OP_W   = 17;
  localparam int PROD_W = OP_W + 1 + DATA_W;
  localparam int ACC_W  = 40;
  localparam int LO_W   = 18;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PLO_W  = LO_W + 1 + DATA_W + 1;
  localparam int PHI_W  = HI_W + DATA_W + 1;
  localparam int SUM_W  = 58;
  localparam int SHIFT_HID = 26;
  localparam int SHIFT_OUT = 34;

  // Bias inputs: 1.0 in Q8.8 for the hidden layer and in Q0.16 for the output layer.
  localparam logic [OP_W-1:0] BIAS_HID_OP = OP_W'(256);
  localparam logic [OP_W-1:0] BIAS_OUT_OP = OP_W'(65536);

  // Request codes.
  localparam logic REQ_WEIGHT  = 1'b0;
  localparam logic REQ_FEATURE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN    = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_ERR,
    ST_START,
    ST_UNIT,
    ST_WAIT
  } seq_state_t;

  typedef struct packed {
    logic               valid;
    logic               wen;
    logic [FEAT_AW-1:0] tag;
  } mag_ctl_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic out_phase;
  } mac_in_t;

  typedef logic [DATA_W-1:0] sig_tab_t [SIGMOID_ENTRIES];

  localparam longint unsigned E_STEP = 64'd4228380001;

  // Rounded quotient by shift and subtract, used at elaboration only.
  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    longint unsigned x;
    longint unsigned q;
    longint unsigned r;
    x = n + (d >> 1);
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], x[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [DATA_W-1:0] sig_entry(longint unsigned p, logic pos);
    longint unsigned den;
    longint unsigned num;
    longint unsigned v;
    den = (64'd1 << 32) + p;
    num = pos ? (64'd1 << 48) : (p << 16);
    v = div_round(num, den);
    return (v > 64'd65535) ? 16'hFFFF : v[DATA_W-1:0];
  endfunction

  // Entry i holds sigmoid((i - half) / 64) in unsigned Q0.16, with e^(-k/64)
  // built up step by step in Q0.32.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t        tab;
    longint unsigned p;
    p = 64'd1 << 32;
    for (int k = 0; k <= SIG_HALF; k++) begin
      if (SIG_HALF + k <= SIGMOID_ENTRIES - 1) tab[SIG_HALF + k] = sig_entry(p, 1'b1);
      if (k > 0 && SIG_HALF - k >= 0) tab[SIG_HALF - k] = sig_entry(p, 1'b0);
      p = (p * E_STEP + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

FILE: rtl/core/mlp_if.sv
// Channel interfaces of the perceptron: feature/weight input, results and configuration.
`default_nettype none
interface mlp_in_if;
  import mlp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [DATA_W-1:0] weight_value;
  logic signed [DATA_W-1:0] feature_re;
  logic signed [DATA_W-1:0] feature_im;
  logic                     feature_last;
  modport source (output valid, req_type, weight_index, weight_value, feature_re,
                  feature_im, feature_last, input ready);
  modport sink (input valid, req_type, weight_index, weight_value, feature_re,
                feature_im, feature_last, output ready);
endinterface

interface mlp_out_if;
  import mlp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OIDX_W-1:0]        output_index;
  logic signed [DATA_W-1:0] output_value;
  logic                     size_error;
  logic                     result_last;
  modport source (output valid, output_index, output_value, size_error, result_last,
                  input ready);
  modport sink (input valid, output_index, output_value, size_error, result_last,
                output ready);
endinterface

interface mlp_cfg_if;
  import mlp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mlp_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per pass.
`default_nettype none
module mlp_sqrt_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mlp_pkg::mag_ctl_t                in_ctl,
  input  logic [mlp_pkg::RAD_W-1:0]        in_rad,
  input  logic [mlp_pkg::REM_W-1:0]        in_rem,
  input  logic [mlp_pkg::SQRT_STEPS-1:0]   in_root,
  output mlp_pkg::mag_ctl_t                out_ctl,
  output logic [mlp_pkg::RAD_W-1:0]        out_rad,
  output logic [mlp_pkg::REM_W-1:0]        out_rem,
  output logic [mlp_pkg::SQRT_STEPS-1:0]   out_root
);
  import mlp_pkg::*;

  logic [REM_W-1:0]      rem_shift;
  logic [REM_W-1:0]      trial;
  logic                  fits;
  mag_ctl_t              ctl_r;
  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [SQRT_STEPS-1:0] root_r;

  always_comb begin
    rem_shift = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
    trial     = REM_W'({in_root, 2'b01});
    fits      = (rem_shift >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= in_ctl.valid;
    end
    ctl_r.wen <= in_ctl.wen;
    ctl_r.tag <= in_ctl.tag;
    rad_r     <= {in_rad[RAD_W-3:0], 2'b00};
    rem_r     <= fits ? (rem_shift - trial) : rem_shift;
    root_r    <= {in_root[SQRT_STEPS-2:0], fits};
  end

  assign out_ctl  = ctl_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;

endmodule
`default_nettype wire

FILE: rtl/core/mlp_mag_chain.sv
// Feature magnitude: squares, sum, then a row of square root cells.
`default_nettype none
module mlp_mag_chain (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mlp_pkg::mag_ctl_t                in_ctl,
  input  logic signed [mlp_pkg::DATA_W-1:0] re,
  input  logic signed [mlp_pkg::DATA_W-1:0] im,
  output mlp_pkg::mag_ctl_t                out_ctl,
  output logic [mlp_pkg::DATA_W-1:0]       mag,
  output logic                             busy
);
  import mlp_pkg::*;

  mag_ctl_t               sq_ctl_r;
  mag_ctl_t               sum_ctl_r;
  logic signed [RAD_W-1:0] re_sq_r;
  logic signed [RAD_W-1:0] im_sq_r;
  logic [RAD_W-1:0]       sum_r;
  mag_ctl_t               ctl_w  [SQRT_STEPS+1];
  logic [RAD_W-1:0]       rad_w  [SQRT_STEPS+1];
  logic [REM_W-1:0]       rem_w  [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0]  root_w [SQRT_STEPS+1];
  logic                   cells_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r.valid  <= 1'b0;
      sum_ctl_r.valid <= 1'b0;
    end else begin
      sq_ctl_r.valid  <= in_ctl.valid;
      sum_ctl_r.valid <= sq_ctl_r.valid;
    end
    sq_ctl_r.wen  <= in_ctl.wen;
    sq_ctl_r.tag  <= in_ctl.tag;
    sum_ctl_r.wen <= sq_ctl_r.wen;
    sum_ctl_r.tag <= sq_ctl_r.tag;
    re_sq_r <= re * re;
    im_sq_r <= im * im;
    sum_r   <= RAD_W'(re_sq_r) + RAD_W'(im_sq_r);
  end

  assign ctl_w[0]  = sum_ctl_r;
  assign rad_w[0]  = sum_r;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
    mlp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_ctl   (ctl_w[g]),
      .in_rad   (rad_w[g]),
      .in_rem   (rem_w[g]),
      .in_root  (root_w[g]),
      .out_ctl  (ctl_w[g+1]),
      .out_rad  (rad_w[g+1]),
      .out_rem  (rem_w[g+1]),
      .out_root (root_w[g+1])
    );
  end

  always_comb begin
    cells_busy = 1'b0;
    for (int i = 1; i <= SQRT_STEPS; i++) begin
      cells_busy = cells_busy | ctl_w[i].valid;
    end
  end

  assign busy    = sq_ctl_r.valid | sum_ctl_r.valid | cells_busy;
  assign out_ctl = ctl_w[SQRT_STEPS];
  assign mag     = root_w[SQRT_STEPS];

endmodule
`default_nettype wire

FILE: rtl/core/mlp_mac_unit.sv
// Multiply-accumulate, gain scaling, table index and sigmoid lookup for one unit.
`default_nettype none
module mlp_mac_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mlp_pkg::mac_in_t                  in_ctl,
  input  logic [mlp_pkg::OP_W-1:0]          operand,
  input  logic signed [mlp_pkg::DATA_W-1:0] weight,
  input  logic [mlp_pkg::DATA_W-1:0]        beta,
  output logic                              done,
  output logic [mlp_pkg::DATA_W-1:0]        sig_value
);
  import mlp_pkg::*;

  localparam logic signed [SUM_W-1:0] IDX_MIN = SUM_W'(-SIG_HALF);
  localparam logic signed [SUM_W-1:0] IDX_MAX = SUM_W'(SIG_HALF - 1);

  mac_in_t                  c1_r;
  logic                     v2_r, v3_r, v4_r, v5_r;
  logic                     p2_r, p3_r, p4_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PLO_W-1:0]  plo_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SIG_IDX_W-1:0]     idx_r;
  logic [DATA_W-1:0]        tab_r;
  logic signed [SUM_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  scaled;
  logic [SIG_IDX_W-1:0]     idx_nxt;

  // Round to the nearest table step and clamp to the table; the shift depends on the layer's fraction bits.
  always_comb begin
    if (p4_r) begin
      rounded = sum_r + (SUM_W'(1) <<< (SHIFT_OUT - 1));
      scaled  = rounded >>> SHIFT_OUT;
    end else begin
      rounded = sum_r + (SUM_W'(1) <<< (SHIFT_HID - 1));
      scaled  = rounded >>> SHIFT_HID;
    end
    if (scaled < IDX_MIN) begin
      idx_nxt = '0;
    end else if (scaled > IDX_MAX) begin
      idx_nxt = '1;
    end else begin
      idx_nxt = SIG_IDX_W'(scaled + SUM_W'(SIG_HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      done <= 1'b0;
    end else begin
      c1_r.valid <= in_ctl.valid;
      v2_r <= c1_r.valid & c1_r.last;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      done <= v5_r;
    end
    c1_r.first     <= in_ctl.first;
    c1_r.last      <= in_ctl.last;
    c1_r.out_phase <= in_ctl.out_phase;
    prod_r <= $signed({1'b0, operand}) * weight;
    if (c1_r.valid) begin
      acc_r <= c1_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    p2_r  <= c1_r.out_phase;
    p3_r  <= p2_r;
    p4_r  <= p3_r;
    plo_r <= $signed({1'b0, acc_r[LO_W-1:0]}) * $signed({1'b0, beta});
    phi_r <= $signed(acc_r[ACC_W-1:LO_W]) * $signed({1'b0, beta});
    sum_r <= (SUM_W'(phi_r) <<< LO_W) + SUM_W'(plo_r);
    idx_r <= idx_nxt;
    tab_r <= SIG_TABLE[idx_r];
  end

  assign sig_value = tab_r;

endmodule
`default_nettype wire

FILE: rtl/core/mlp_two_layer_forward.sv
// Top level of the two-layer perceptron forward pass with weight store and sequencer.
// A weight write goes into the weight store on transfer; each feature passes the magnitude
// chain. After the last feature, one MAC per cycle is issued, limited by the weight port,
// while a unit's weights go out; it waits between units for the activation and result space.
// Throughput: one input transfer per cycle while idle; none is taken during a run.
// Reset (synchronous, active low) restores the register defaults and clears the feature
// count and control state; the weight, feature and hidden stores keep their contents.
`default_nettype none
module mlp_two_layer_forward (
  input  logic          clk,
  input  logic          rst_n,
  mlp_in_if.sink        in_chan,
  mlp_out_if.source     out_chan,
  mlp_cfg_if.sink       cfg_chan
);
  import mlp_pkg::*;

  localparam int CMP_W = (CNT_W > NI_W) ? CNT_W : NI_W;

  // Configuration registers.
  logic [ICNT_REG_W-1:0] in_cnt_r;
  logic [HCNT_REG_W-1:0] hid_cnt_r;
  logic [OCNT_REG_W-1:0] out_cnt_r;
  logic [DATA_W-1:0]     beta_r;
  logic [NI_W-1:0]       ni;
  logic [NH_W-1:0]       nh;
  logic [NO_W-1:0]       no;

  // Stores. The weight store is a memory with a registered read port.
  logic [DATA_W-1:0] wmem   [WEIGHT_DEPTH];
  logic [DATA_W-1:0] feat_r [MAX_INPUTS];
  logic [DATA_W-1:0] hid_r  [MAX_HIDDEN];
  logic signed [DATA_W-1:0] w_rd_r;

  // Feature collection.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_sat;
  logic             err_r;
  logic             in_xfer;
  mag_ctl_t         mag_in;
  mag_ctl_t         mag_out;
  logic [DATA_W-1:0] mag;
  logic             mag_busy;

  // Sequencer.
  seq_state_t        state_r, state_nxt;
  logic              phase_r;
  logic [UNIT_W-1:0] unit_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SEQ_AW-1:0] addr_r;
  logic [SEQ_AW-1:0] base_r;
  logic [SEQ_AW-1:0] stride;
  logic              slot_last;
  logic              unit_last;
  logic [OP_W-1:0]   operand;
  logic [DATA_W-1:0] feat_rd;
  logic [DATA_W-1:0] hid_rd;
  mac_in_t           iss_r;
  logic [OP_W-1:0]   op_r;
  logic              mac_done;
  logic [DATA_W-1:0] mac_s;

  // Result register.
  logic              out_valid_r;
  logic [OIDX_W-1:0] out_idx_r;
  logic [DATA_W-1:0] out_val_r;
  logic              out_err_r;
  logic              out_last_r;
  logic              out_load;

  // The configuration port never stalls; unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= ICNT_REG_W'(32);
      hid_cnt_r <= HCNT_REG_W'(32);
      out_cnt_r <= OCNT_REG_W'(16);
      beta_r    <= DATA_W'(4096);
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_INPUT_COUNT:  in_cnt_r  <= cfg_chan.wdata[ICNT_REG_W-1:0];
        REG_HIDDEN_COUNT: hid_cnt_r <= cfg_chan.wdata[HCNT_REG_W-1:0];
        REG_OUTPUT_COUNT: out_cnt_r <= cfg_chan.wdata[OCNT_REG_W-1:0];
        REG_BETA_GAIN:    beta_r    <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // Counts in use are the register values clamped to one up to the store size.
  always_comb begin
    if (in_cnt_r == '0) ni = NI_W'(1);
    else if (int'(in_cnt_r) > MAX_INPUTS) ni = NI_W'(MAX_INPUTS);
    else ni = NI_W'(in_cnt_r);
    if (hid_cnt_r == '0) nh = NH_W'(1);
    else if (int'(hid_cnt_r) > MAX_HIDDEN) nh = NH_W'(MAX_HIDDEN);
    else nh = NH_W'(hid_cnt_r);
    if (out_cnt_r == '0) no = NO_W'(1);
    else if (int'(out_cnt_r) > MAX_OUTPUTS) no = NO_W'(MAX_OUTPUTS);
    else no = NO_W'(out_cnt_r);
  end

  // Input side: transfers are taken only while no run is pending.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid & in_chan.ready;
  assign cnt_sat       = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);

  // Magnitudes land in the slot counted at transfer time; slots past the store are dropped.
  always_comb begin
    mag_in.valid = in_xfer & (in_chan.req_type == REQ_FEATURE);
    mag_in.wen   = (int'(cnt_r) < MAX_INPUTS);
    mag_in.tag   = FEAT_AW'(cnt_r);
  end

  mlp_mag_chain u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (mag_in),
    .re      (in_chan.feature_re),
    .im      (in_chan.feature_im),
    .out_ctl (mag_out),
    .mag     (mag),
    .busy    (mag_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (mag_in.valid) begin
      if (in_chan.feature_last) begin
        cnt_r <= '0;
        err_r <= (CMP_W'(cnt_sat) != CMP_W'(ni));
      end else begin
        cnt_r <= cnt_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mag_out.valid && mag_out.wen) begin
      feat_r[mag_out.tag] <= mag;
    end
  end

  // Weight memory: writes come from the input channel, reads from the sequencer.
  always_ff @(posedge clk) begin
    if (in_xfer && in_chan.req_type == REQ_WEIGHT) begin
      wmem[WADDR_W'(in_chan.weight_index)] <= in_chan.weight_value;
    end
    w_rd_r <= wmem[addr_r[WADDR_W-1:0]];
  end

  // Slot zero is the bias; slot j then reads the layer input j-1.
  always_comb begin
    feat_rd   = feat_r[FEAT_AW'(slot_r - SLOT_W'(1))];
    hid_rd    = hid_r[HID_AW'(slot_r - SLOT_W'(1))];
    stride    = phase_r ? SEQ_AW'(no) : SEQ_AW'(nh);
    slot_last = phase_r ? (slot_r == SLOT_W'(nh)) : (slot_r == SLOT_W'(ni));
    unit_last = phase_r ? ((unit_r + UNIT_W'(1)) == UNIT_W'(no))
                        : ((unit_r + UNIT_W'(1)) == UNIT_W'(nh));
    if (slot_r == '0) operand = phase_r ? BIAS_OUT_OP : BIAS_HID_OP;
    else operand = phase_r ? OP_W'(hid_rd) : OP_W'(feat_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The run goes unit by unit: every weight of a unit is issued, then the sequencer
  // waits for the activation before starting the next one. Output units start only
  // once the previous result has been transferred.
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (mag_in.valid && in_chan.feature_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mag_busy) state_nxt = err_r ? ST_ERR : ST_START;
      end
      ST_ERR: begin
        if (!out_valid_r) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        if (!(phase_r && out_valid_r)) state_nxt = ST_UNIT;
      end
      ST_UNIT: begin
        if (slot_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          out_load  = phase_r;
          state_nxt = (phase_r && unit_last) ? ST_IDLE : ST_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      unit_r      <= '0;
      slot_r      <= '0;
      iss_r.valid <= 1'b0;
    end else begin
      iss_r.valid <= (state_r == ST_UNIT);
      case (state_r)
        ST_DRAIN: begin
          phase_r <= 1'b0;
          unit_r  <= '0;
          base_r  <= (SEQ_AW'(ni) + SEQ_AW'(1)) * SEQ_AW'(nh);
        end
        ST_START: begin
          slot_r <= '0;
          addr_r <= phase_r ? base_r + SEQ_AW'(unit_r) : SEQ_AW'(unit_r);
        end
        ST_UNIT: begin
          slot_r <= slot_r + SLOT_W'(1);
          addr_r <= addr_r + stride;
        end
        ST_WAIT: begin
          if (mac_done) begin
            if (!phase_r && unit_last) begin
              phase_r <= 1'b1;
              unit_r  <= '0;
            end else begin
              unit_r <= unit_r + UNIT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
    iss_r.first     <= (slot_r == '0);
    iss_r.last      <= slot_last;
    iss_r.out_phase <= phase_r;
    op_r            <= operand;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && mac_done && !phase_r) begin
      hid_r[HID_AW'(unit_r)] <= mac_s;
    end
  end

  mlp_mac_unit u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (iss_r),
    .operand   (op_r),
    .weight    (w_rd_r),
    .beta      (beta_r),
    .done      (mac_done),
    .sig_value (mac_s)
  );

  // Result register: an output activation is 2*sigmoid-1, which in Q1.15 is the
  // table value with its top bit flipped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      if (state_r == ST_ERR) begin
        out_idx_r  <= '0;
        out_val_r  <= '0;
        out_err_r  <= 1'b1;
        out_last_r <= 1'b1;
      end else begin
        out_idx_r  <= OIDX_W'(unit_r);
        out_val_r  <= {~mac_s[DATA_W-1], mac_s[DATA_W-2:0]};
        out_err_r  <= 1'b0;
        out_last_r <= unit_last;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.output_index = out_idx_r;
  assign out_chan.output_value = out_val_r;
  assign out_chan.size_error   = out_err_r;
  assign out_chan.result_last  = out_last_r;

`ifndef SYNTHESIS
  a_mag_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mag_out.valid |-> (state_r == ST_IDLE || state_r == ST_DRAIN))
    else $error("magnitude written during a run");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNIT) |-> (phase_r ? (slot_r <= SLOT_W'(nh)) : (slot_r <= SLOT_W'(ni))))
    else $error("weight slot beyond layer size");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_WAIT))
    else $error("activation arrived outside wait state");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("result register overwritten");
  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNIT) |-> !in_xfer)
    else $error("input taken during a run");
`endif

endmodule
`default_nettype wire
